FILE: src/audio_sample_queue_mixer_macros.svh
// ----------------------------------------------------------------------------
// audio sample queue mixer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef AUDIO_SAMPLE_QUEUE_MIXER_MACROS_SVH
`define AUDIO_SAMPLE_QUEUE_MIXER_MACROS_SVH

// same-cycle implication
`define ASQM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/asqm_pkg.sv
// ----------------------------------------------------------------------------
// asqm_pkg
// widths, codes, types and helpers shared by the audio sample queue mixer
// ----------------------------------------------------------------------------
package asqm_pkg;

  localparam int QUEUE_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_N_W     = COUNT_W + 1;
  localparam int DIV_STEP_W  = $clog2(DIV_N_W + 1);

  localparam int CMD_W       = 2;
  localparam int SAMPLE_W    = 24;
  localparam int PCM_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int FRAME_W     = 11;
  localparam int LIMIT_W     = 15;
  localparam int QUEUED_W    = 15;
  localparam int CREDIT_W    = 32;
  localparam int POS_W       = 10;
  localparam int PAIR_W      = 2 * PCM_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int FRAME_MAX   = 1024;
  localparam int GAIN_RESET  = 16384;
  localparam int FRAME_RESET = 768;
  localparam int LIMIT_RESET = 16000;

  // q2.22 * q2.14 * 32767 / 2^36
  localparam int PCM_SCALE_SH = 15;
  localparam int FRAC_SHIFT   = 36;
  localparam int PCM_MAX      = 32767;
  localparam int PCM_MIN_MAG  = 32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_DRAIN    = 2'd1,
    CMD_SHUTDOWN = 2'd2,
    CMD_UNUSED   = 2'd3
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_PAUSED = 2'd1,
    REG_FRAME  = 2'd2,
    REG_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB_L,
    ST_SUB_R,
    ST_SUB_WAIT,
    ST_SUB_WR,
    ST_DRN_RD,
    ST_DRN_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [FRAME_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_res_t;

  function automatic logic [FRAME_W-1:0] eff_frame(input logic [FRAME_W-1:0] f);
    logic [FRAME_W-1:0] r;
    if (f == '0) begin
      r = FRAME_W'(1);
    end else if (f > FRAME_W'(FRAME_MAX)) begin
      r = FRAME_W'(FRAME_MAX);
    end else begin
      r = f;
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] l);
    logic [COUNT_W-1:0] r;
    if (l == '0) begin
      r = COUNT_W'(1);
    end else if (32'(l) > 32'(QUEUE_DEPTH)) begin
      r = COUNT_W'(QUEUE_DEPTH);
    end else begin
      r = COUNT_W'(l);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] i);
    logic [ADDR_W-1:0] r;
    if (i == ADDR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + ADDR_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: src/asqm_if.sv
// ----------------------------------------------------------------------------
// asqm channel interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface asqm_req_if;
  import asqm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic signed [PCM_W-1:0]    mix_left;
  logic signed [PCM_W-1:0]    mix_right;

  modport source (
    output valid, command, left_sample, right_sample, mix_left, mix_right,
    input  ready
  );
  modport sink (
    input  valid, command, left_sample, right_sample, mix_left, mix_right,
    output ready
  );
endinterface

interface asqm_rsp_if;
  import asqm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PCM_W-1:0] out_left;
  logic signed [PCM_W-1:0] out_right;
  logic                    taken;
  logic [CREDIT_W-1:0]     released;
  logic [QUEUED_W-1:0]     queued_pairs;

  modport source (
    output valid, out_left, out_right, taken, released, queued_pairs,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_right, taken, released, queued_pairs,
    output ready
  );
endinterface

FILE: src/asqm_pair_ram.sv
// ----------------------------------------------------------------------------
// asqm_pair_ram
// simple dual-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module asqm_pair_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read before write on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/asqm_scale.sv
// ----------------------------------------------------------------------------
// asqm_scale
// two-stage gain and pcm conversion pipe, one sample per cycle
// ----------------------------------------------------------------------------
module asqm_scale (
  input  logic                                clk,
  input  logic signed [asqm_pkg::SAMPLE_W-1:0] sample,
  input  logic [asqm_pkg::GAIN_W-1:0]          gain,
  output logic signed [asqm_pkg::PCM_W-1:0]    pcm
);
  import asqm_pkg::*;

  localparam int PROD_W = SAMPLE_W + GAIN_W;
  localparam int Y_W    = PROD_W + PCM_SCALE_SH;
  localparam int Q_W    = Y_W - FRAC_SHIFT;

  logic [SAMPLE_W-1:0] mag;
  logic [PROD_W-1:0]   prod;
  logic                neg;
  logic [Y_W-1:0]      y;
  logic [Q_W-1:0]      q;
  logic [Q_W-1:0]      q_neg;
  logic [PCM_W-1:0]    pcm_next;

  // stage 1: magnitude times gain
  assign mag = sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - SAMPLE_W'(sample)) : SAMPLE_W'(sample);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mag) * PROD_W'(gain);
    neg  <= sample[SAMPLE_W-1];
  end

  // stage 2: times 32767 as shift minus one, truncate, saturate
  always_comb begin
    y     = (Y_W'(prod) << PCM_SCALE_SH) - Y_W'(prod);
    q     = y[Y_W-1:FRAC_SHIFT];
    q_neg = Q_W'(0) - q;
    if (neg) begin
      if (q > Q_W'(PCM_MIN_MAG)) begin
        pcm_next = PCM_W'(PCM_MIN_MAG);
      end else begin
        pcm_next = q_neg[PCM_W-1:0];
      end
    end else begin
      if (q > Q_W'(PCM_MAX)) begin
        pcm_next = PCM_W'(PCM_MAX);
      end else begin
        pcm_next = q[PCM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pcm <= signed'(pcm_next);
  end

endmodule

FILE: src/asqm_div.sv
// ----------------------------------------------------------------------------
// asqm_div
// restoring divider, one quotient bit per cycle, for the credit count
// ----------------------------------------------------------------------------
`include "audio_sample_queue_mixer_macros.svh"

module asqm_div (
  input  logic               clk,
  input  logic               rst,
  input  asqm_pkg::div_cmd_t cmd,
  output asqm_pkg::div_res_t res
);
  import asqm_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] steps;
  logic [DIV_N_W-1:0]    num;
  logic [DIV_N_W-1:0]    quo;
  logic [FRAME_W-2:0]    rem;
  logic [FRAME_W-1:0]    divisor;
  logic [FRAME_W-1:0]    trial;
  logic                  fits;

  assign trial = {rem, num[DIV_N_W-1]};
  assign fits  = trial >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      if (cmd.start) begin
        busy  <= 1'b1;
        done  <= 1'b0;
        steps <= DIV_STEP_W'(DIV_N_W);
      end else if (busy) begin
        // last step clears busy and raises done for one cycle
        steps <= steps - DIV_STEP_W'(1);
        busy  <= (steps != DIV_STEP_W'(1));
        done  <= (steps == DIV_STEP_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num     <= cmd.dividend;
      divisor <= cmd.divisor;
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      num <= {num[DIV_N_W-2:0], 1'b0};
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= fits ? (FRAME_W-1)'(trial - divisor) : trial[FRAME_W-2:0];
    end
  end

  assign res.busy     = busy;
  assign res.done     = done;
  assign res.quotient = quo;

  `ASQM_ASSERT_NEXT(a_done_pulse, done, !done, "divider done held for more than a cycle")
  `ASQM_ASSERT_IMPL(a_busy_from_start, $rose(busy), $past(cmd.start), "divider busy without start")
  `ASQM_ASSERT_IMPL(a_divisor_held, busy && $past(busy), $stable(divisor), "divisor changed mid-division")

endmodule

FILE: src/audio_sample_queue_mixer.sv
// ----------------------------------------------------------------------------
// audio_sample_queue_mixer
// bounded stereo pcm queue with gain, frame credit tracking and mix-on-drain
// ----------------------------------------------------------------------------
// One item is handled at a time; req.ready is high only while the block is idle, and a
// finished result sits in the output register while the next item is taken. A submit is
// accepted, issues the left and then the right sample into the shared two-stage scaling pipe,
// latches the scaled left sample, writes the pair and hands off; a drain pops a pair if one is
// queued and then waits on the one-bit-per-cycle credit divider that works out ceil(pairs / frame),
// and shutdown and the unused command hand off at once. The pair store is a QUEUE_DEPTH x 32 single
// ram (left in the low half), read at the head index and written at the tail index; it has
// no clearing pass, since only entries holding queued pairs are ever read. Configuration is
// written through cfg_write / cfg_index / cfg_data; it takes effect at once, even mid-item.
// ----------------------------------------------------------------------------
`include "audio_sample_queue_mixer_macros.svh"

module audio_sample_queue_mixer (
  input  logic                             clk,
  input  logic                             rst,
  asqm_req_if.sink                         req,
  asqm_rsp_if.source                       rsp,
  input  logic                             cfg_write,
  input  logic [asqm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asqm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import asqm_pkg::*;

  // control
  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;
  logic   ram_we;

  // configuration registers
  logic [GAIN_W-1:0]  gain;
  logic               paused;
  logic [FRAME_W-1:0] frame_pairs;
  logic [LIMIT_W-1:0] queue_limit_pairs;

  // queue bookkeeping
  logic [ADDR_W-1:0]   head;
  logic [ADDR_W-1:0]   tail;
  logic [COUNT_W-1:0]  count;
  logic [CREDIT_W-1:0] unreleased;
  logic [POS_W-1:0]    frame_pos;

  // latched item
  logic [CMD_W-1:0]           item_cmd;
  logic signed [SAMPLE_W-1:0] item_left;
  logic signed [SAMPLE_W-1:0] item_right;
  logic signed [PCM_W-1:0]    item_mix_left;
  logic signed [PCM_W-1:0]    item_mix_right;

  // pending result
  logic signed [PCM_W-1:0] res_left;
  logic signed [PCM_W-1:0] res_right;
  logic                    res_taken;
  logic [CREDIT_W-1:0]     res_released;
  logic [QUEUED_W-1:0]     res_queued;

  // output register
  logic                    rsp_valid;
  logic signed [PCM_W-1:0] rsp_left;
  logic signed [PCM_W-1:0] rsp_right;
  logic                    rsp_taken;
  logic [CREDIT_W-1:0]     rsp_released;
  logic [QUEUED_W-1:0]     rsp_queued;

  // datapath
  logic signed [SAMPLE_W-1:0] scale_in;
  logic [GAIN_W-1:0]          scale_gain;
  logic signed [PCM_W-1:0]    scale_out;
  logic signed [PCM_W-1:0]    pcm_left;
  logic [PAIR_W-1:0]          ram_rdata;
  logic [FRAME_W-1:0]         fp;
  logic [COUNT_W-1:0]         lim;
  logic                       drop;
  logic                       have_pair;
  logic [COUNT_W-1:0]         count_drain;
  logic [CREDIT_W-1:0]        pending;
  div_cmd_t                   div_cmd;
  div_res_t                   div_res;

  assign fp          = eff_frame(frame_pairs);
  assign lim         = eff_limit(queue_limit_pairs);
  assign drop        = count >= lim;
  assign have_pair   = count != '0;
  assign count_drain = have_pair ? (count - COUNT_W'(1)) : count;
  assign pending     = CREDIT_W'(div_res.quotient);

  function automatic logic signed [PCM_W-1:0] mix_sat(input logic signed [PCM_W-1:0] a,
                                                      input logic signed [PCM_W-1:0] b);
    logic signed [PCM_W:0] s;
    logic signed [PCM_W-1:0] r;
    s = {a[PCM_W-1], a} + {b[PCM_W-1], b};
    if (s[PCM_W] != s[PCM_W-1]) begin
      r = s[PCM_W] ? signed'(PCM_W'(PCM_MIN_MAG)) : signed'(PCM_W'(PCM_MAX));
    end else begin
      r = s[PCM_W-1:0];
    end
    return r;
  endfunction

  // shared scaling pipe: left issued first, right issued in the next cycle
  assign scale_in   = (state == ST_SUB_R) ? item_right : item_left;
  assign scale_gain = paused ? '0 : gain;

  asqm_scale u_scale (
    .clk    (clk),
    .sample (scale_in),
    .gain   (scale_gain),
    .pcm    (scale_out)
  );

  // read port always follows the head; data is valid the cycle after accept
  asqm_pair_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (PAIR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata ({scale_out, pcm_left}),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // credit divider: pending frames = ceil(pairs left / frame)
  assign div_cmd.start    = (state == ST_DRN_RD);
  assign div_cmd.dividend = DIV_N_W'(count_drain) + DIV_N_W'(fp) - DIV_N_W'(1);
  assign div_cmd.divisor  = fp;

  asqm_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .res (div_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    accept     = 1'b0;
    out_free   = !rsp_valid || rsp.ready;
    ram_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        accept = req.valid;
        if (req.valid) begin
          unique case (command_t'(req.command))
            CMD_SUBMIT:   state_next = ST_SUB_L;
            CMD_DRAIN:    state_next = ST_DRN_RD;
            CMD_SHUTDOWN: state_next = ST_DONE;
            CMD_UNUSED:   state_next = ST_DONE;
          endcase
        end
      end
      ST_SUB_L:    state_next = ST_SUB_R;
      ST_SUB_R:    state_next = ST_SUB_WAIT;
      ST_SUB_WAIT: state_next = ST_SUB_WR;
      ST_SUB_WR: begin
        ram_we     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DRN_RD:   state_next = ST_DRN_DIV;
      ST_DRN_DIV: begin
        if (div_res.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // configuration and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain              <= GAIN_W'(GAIN_RESET);
      paused            <= 1'b0;
      frame_pairs       <= FRAME_W'(FRAME_RESET);
      queue_limit_pairs <= LIMIT_W'(LIMIT_RESET);
      head              <= '0;
      tail              <= '0;
      count             <= '0;
      unreleased        <= '0;
      frame_pos         <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_GAIN:   gain              <= cfg_data[GAIN_W-1:0];
          REG_PAUSED: paused            <= cfg_data[0];
          REG_FRAME:  frame_pairs       <= cfg_data[FRAME_W-1:0];
          REG_LIMIT:  queue_limit_pairs <= cfg_data[LIMIT_W-1:0];
        endcase
      end
      if (accept && (command_t'(req.command) == CMD_SHUTDOWN)) begin
        head       <= '0;
        tail       <= '0;
        count      <= '0;
        frame_pos  <= '0;
        unreleased <= '0;
      end
      if (state == ST_SUB_WR) begin
        // a queue at or over its limit drops the oldest pair before the append
        if (drop) begin
          head <= next_index(head);
        end
        count <= (drop ? count : count + COUNT_W'(1));
        tail  <= next_index(tail);
        if ((FRAME_W'(frame_pos) + FRAME_W'(1)) >= fp) begin
          frame_pos <= '0;
          if (unreleased != '1) begin
            unreleased <= unreleased + CREDIT_W'(1);
          end
        end else begin
          frame_pos <= frame_pos + POS_W'(1);
        end
      end
      if ((state == ST_DRN_RD) && have_pair) begin
        head  <= next_index(head);
        count <= count_drain;
      end
      if ((state == ST_DRN_DIV) && div_res.done && (unreleased > pending)) begin
        unreleased <= pending;
      end
    end
  end

  // item latch, pending result and scaled left sample
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd       <= req.command;
      item_left      <= req.left_sample;
      item_right     <= req.right_sample;
      item_mix_left  <= req.mix_left;
      item_mix_right <= req.mix_right;
      // pass-through defaults; shutdown and unused finish here
      res_left     <= req.mix_left;
      res_right    <= req.mix_right;
      res_taken    <= 1'b0;
      res_released <= (command_t'(req.command) == CMD_SHUTDOWN) ? unreleased : '0;
      res_queued   <= (command_t'(req.command) == CMD_SHUTDOWN) ? '0 : QUEUED_W'(count);
    end
    if (state == ST_SUB_WAIT) begin
      pcm_left <= scale_out;
    end
    if (state == ST_SUB_WR) begin
      res_queued <= QUEUED_W'(drop ? count : count + COUNT_W'(1));
    end
    if (state == ST_DRN_RD) begin
      res_queued <= QUEUED_W'(count_drain);
      if (have_pair) begin
        res_left  <= mix_sat(item_mix_left, ram_rdata[PCM_W-1:0]);
        res_right <= mix_sat(item_mix_right, ram_rdata[PAIR_W-1:PCM_W]);
        res_taken <= 1'b1;
      end
    end
    if ((state == ST_DRN_DIV) && div_res.done && (unreleased > pending)) begin
      res_released <= unreleased - pending;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      rsp_left     <= res_left;
      rsp_right    <= res_right;
      rsp_taken    <= res_taken;
      rsp_released <= res_released;
      rsp_queued   <= res_queued;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.out_left     = rsp_left;
  assign rsp.out_right    = rsp_right;
  assign rsp.taken        = rsp_taken;
  assign rsp.released     = rsp_released;
  assign rsp.queued_pairs = rsp_queued;

  `ASQM_ASSERT_NEXT(a_idle_holds_count, state == ST_IDLE && !accept, $stable(count), "queue count moved while idle")
  `ASQM_ASSERT_IMPL(a_div_done_in_drain, div_res.done, state == ST_DRN_DIV, "divider finished outside a drain")
  `ASQM_ASSERT_IMPL(a_div_free_on_start, div_cmd.start, !div_res.busy, "divider restarted while busy")
  `ASQM_ASSERT_NEXT(a_submit_no_credit, state == ST_SUB_WR, res_released == '0 && !res_taken, "submit result carries credits or a pop")
  `ASQM_ASSERT_IMPL(a_drain_cmd, state == ST_DRN_RD, command_t'(item_cmd) == CMD_DRAIN, "drain path entered for a non-drain item")

endmodule

FILE: tb/tb_audio_sample_queue_mixer.sv
// ----------------------------------------------------------------------------
// tb_audio_sample_queue_mixer
// self-checking bench: directed table then random phases, scored against a
// cycle-free model of the queue, the gain scaling and the frame credits
// ----------------------------------------------------------------------------
module tb_audio_sample_queue_mixer;
  import asqm_pkg::*;

  typedef struct {
    logic signed [PCM_W-1:0] left_out;
    logic signed [PCM_W-1:0] right_out;
    logic                    taken;
    logic [CREDIT_W-1:0]     released;
    logic [QUEUED_W-1:0]     queued;
  } mix_result_t;

  // one row of stimulus: either a register write or a command item
  typedef struct {
    bit                   is_write;
    cfg_reg_t             sel;
    logic [CFG_DATA_W-1:0] wdata;
    command_t             cmd;
    logic [SAMPLE_W-1:0]  ls;
    logic [SAMPLE_W-1:0]  rs;
    logic [PCM_W-1:0]     ml;
    logic [PCM_W-1:0]     mr;
    bit                   typed;
    mix_result_t          want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  asqm_req_if req ();
  asqm_rsp_if rsp ();

  audio_sample_queue_mixer u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // model state: the queue is kept as a plain fifo of packed pairs
  // (right in the upper half), the ring indices are not visible from outside
  logic [PAIR_W-1:0]   held_pairs[$];
  logic [CREDIT_W-1:0] open_frames = '0;
  int unsigned         frame_pos   = 0;

  // register copies, reset values as the block comes out of reset
  logic [GAIN_W-1:0]   gain_r   = GAIN_W'(GAIN_RESET);
  logic                paused_r = 1'b0;
  logic [FRAME_W-1:0]  frame_r  = FRAME_W'(FRAME_RESET);
  logic [LIMIT_W-1:0]  limit_r  = LIMIT_W'(LIMIT_RESET);

  mix_result_t awaited_results[$];
  stim_row_t   plan[$];
  int          fails       = 0;
  int          items_in    = 0;
  bit          steady_send = 1'b0;

  // ----------------------------------------------------------------------------
  // model helpers
  // ----------------------------------------------------------------------------

  // q2.22 sample times q2.14 gain times 32767 over 2^36, toward zero, clipped
  function automatic logic [PCM_W-1:0] q22_to_pcm(logic [SAMPLE_W-1:0] s,
                                                  logic [GAIN_W-1:0] g);
    longint     sv;
    logic [63:0] mag;
    logic [63:0] q;
    sv  = longint'($signed(s));
    mag = (sv < 0) ? -sv : sv;
    q   = (mag * 64'(g) * 64'd32767) >> 36;
    if (sv >= 0) begin
      return (q > 64'd32767) ? 16'h7fff : q[15:0];
    end
    return (q > 64'd32768) ? 16'h8000 : (~q[15:0]) + 16'd1;
  endfunction

  function automatic logic [PCM_W-1:0] clip_sum(logic signed [PCM_W-1:0] a,
                                                logic signed [PCM_W-1:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32767) return 16'h7fff;
    if (s < -32768) return 16'h8000;
    return s[15:0];
  endfunction

  // out-of-range frame sizes and limits clamp into the legal window
  function automatic int unsigned frame_len();
    if (frame_r == '0) return 1;
    if (frame_r > FRAME_MAX) return FRAME_MAX;
    return frame_r;
  endfunction

  function automatic int unsigned queue_cap();
    if (limit_r == '0) return 1;
    if (limit_r > QUEUE_DEPTH) return QUEUE_DEPTH;
    return limit_r;
  endfunction

  // advances the model by one accepted item and returns what the block owes
  function automatic mix_result_t next_mix_result(stim_row_t it);
    mix_result_t       res;
    logic [GAIN_W-1:0] g;
    logic [PAIR_W-1:0] pair;
    int unsigned       fp;
    int unsigned       pending;
    res.left_out  = it.ml;
    res.right_out = it.mr;
    res.taken     = 1'b0;
    res.released  = '0;
    case (it.cmd)
      CMD_SUBMIT: begin
        g = paused_r ? '0 : gain_r;
        // at the limit the oldest pair makes room
        if (held_pairs.size() >= queue_cap()) void'(held_pairs.pop_front());
        held_pairs.insert(held_pairs.size(), {q22_to_pcm(it.rs, g), q22_to_pcm(it.ls, g)});
        // frame ends once the position reaches the current size, even if the
        // size shrank mid-frame
        if (frame_pos + 1 >= frame_len()) begin
          frame_pos = 0;
          if (open_frames != '1) open_frames++;
        end else begin
          frame_pos++;
        end
      end
      CMD_DRAIN: begin
        if (held_pairs.size() > 0) begin
          pair          = held_pairs.pop_front();
          res.left_out  = clip_sum(it.ml, pair[PCM_W-1:0]);
          res.right_out = clip_sum(it.mr, pair[PAIR_W-1:PCM_W]);
          res.taken     = 1'b1;
        end
        // credit check runs even when nothing was popped
        fp      = frame_len();
        pending = (held_pairs.size() + fp - 1) / fp;
        if (open_frames > pending) begin
          res.released = open_frames - pending;
          open_frames  = pending;
        end
      end
      CMD_SHUTDOWN: begin
        held_pairs.delete();
        frame_pos    = 0;
        res.released = open_frames;
        open_frames  = '0;
      end
      default: begin
      end
    endcase
    res.queued = QUEUED_W'(held_pairs.size());
    return res;
  endfunction

  // ----------------------------------------------------------------------------
  // stimulus helpers
  // ----------------------------------------------------------------------------

  function automatic stim_row_t op_row(command_t c, int ls, int rs, int ml, int mr);
    stim_row_t r;
    r.is_write = 1'b0;
    r.sel      = REG_GAIN;
    r.wdata    = '0;
    r.cmd      = c;
    r.ls       = SAMPLE_W'(ls);
    r.rs       = SAMPLE_W'(rs);
    r.ml       = PCM_W'(ml);
    r.mr       = PCM_W'(mr);
    r.typed    = 1'b0;
    r.want     = '{default: '0};
    return r;
  endfunction

  // row whose outcome is obvious enough to type in directly
  function automatic stim_row_t known_row(command_t c, int ls, int rs, int ml, int mr,
                                          int ol, int orr, bit tk, longint rel, int q);
    stim_row_t r;
    r                = op_row(c, ls, rs, ml, mr);
    r.typed          = 1'b1;
    r.want.left_out  = PCM_W'(ol);
    r.want.right_out = PCM_W'(orr);
    r.want.taken     = tk;
    r.want.released  = CREDIT_W'(rel);
    r.want.queued    = QUEUED_W'(q);
    return r;
  endfunction

  function automatic stim_row_t wr_row(cfg_reg_t sel, int data);
    stim_row_t r;
    r          = op_row(CMD_SUBMIT, 0, 0, 0, 0);
    r.is_write = 1'b1;
    r.sel      = sel;
    r.wdata    = CFG_DATA_W'(data);
    return r;
  endfunction

  // appends one row to the directed table
  function automatic void add_row(stim_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // sample values biased toward full scale, unity and tiny magnitudes
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 6))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'h400000 + SAMPLE_W'($urandom_range(0, 15)) - 24'd8;
      3: return 24'hc00000 + SAMPLE_W'($urandom_range(0, 15)) - 24'd8;
      4: return SAMPLE_W'($urandom_range(0, 511)) - 24'd256;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [PCM_W-1:0] pick_mix();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return PCM_W'($urandom());
    endcase
  endfunction

  // one item on the request channel, with a random, possibly empty, gap after it unless steady_send is set
  task automatic send(stim_row_t it);
    mix_result_t guess;
    int          gap;
    int          roll;
    req.valid        <= 1'b1;
    req.command      <= it.cmd;
    req.left_sample  <= it.ls;
    req.right_sample <= it.rs;
    req.mix_left     <= it.ml;
    req.mix_right    <= it.mr;
    do @(posedge clk); while (!req.ready);
    guess = next_mix_result(it);
    awaited_results.insert(awaited_results.size(), it.typed ? it.want : guess);
    items_in++;
    if (!steady_send) begin
      roll = $urandom_range(0, 99);
      gap  = (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and let every owed result come back
  task automatic go_idle();
    req.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (sel)
      REG_GAIN:   gain_r   = data[GAIN_W-1:0];
      REG_PAUSED: paused_r = data[0];
      REG_FRAME:  frame_r  = data[FRAME_W-1:0];
      REG_LIMIT:  limit_r  = data[LIMIT_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    if (fails < 40) $display("mismatch on %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  // ----------------------------------------------------------------------------
  // result checking: every accepted result against the oldest expectation
  // ----------------------------------------------------------------------------
  always @(posedge clk) begin
    mix_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (awaited_results.size() == 0) begin
        report("result with nothing awaited", 1, 0);
      end else begin
        want = awaited_results.pop_front();
        if (rsp.out_left !== want.left_out) report("out_left", rsp.out_left, want.left_out);
        if (rsp.out_right !== want.right_out)
          report("out_right", rsp.out_right, want.right_out);
        if (rsp.taken !== want.taken) report("taken", rsp.taken, want.taken);
        if (rsp.released !== want.released)
          report("released", rsp.released, want.released);
        if (rsp.queued_pairs !== want.queued)
          report("queued_pairs", rsp.queued_pairs, want.queued);
      end
    end
  end

  // ----------------------------------------------------------------------------
  // result receiver: alternates smooth and choppy stretches, and once holds
  // off for a long spell so the block backs up and stalls its input
  // ----------------------------------------------------------------------------
  initial begin
    int stall;
    int hold;
    bit held_once;
    int mode_left;
    bit choppy;
    stall     = 0;
    hold      = 0;
    held_once = 1'b0;
    mode_left = 0;
    choppy    = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && items_in >= 700) begin
        held_once = 1'b1;
        hold      = 400;
      end
      if (mode_left == 0) begin
        choppy    = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if (choppy && $urandom_range(0, 3) == 0) begin
        // mostly short stalls, now and then a long one
        stall     = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  // ----------------------------------------------------------------------------
  // main sequence
  // ----------------------------------------------------------------------------
  initial begin
    stim_row_t           it;
    int                  sub_pct;
    int                  roll;
    logic [CFG_DATA_W-1:0] v;

    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= REG_GAIN;
    cfg_data         <= '0;
    req.valid        <= 1'b0;
    req.command      <= CMD_SUBMIT;
    req.left_sample  <= '0;
    req.right_sample <= '0;
    req.mix_left     <= '0;
    req.mix_right    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table, reset configuration first
    // drain on an empty queue and the unused command just pass the mix through
    add_row(known_row(CMD_DRAIN, 0, 0, -32768, 32767, -32768, 32767, 0, 0, 0));
    add_row(known_row(CMD_UNUSED, 'h7fffff, 'h800000, 123, -456, 123, -456, 0, 0, 0));
    // full-scale samples clip both ways, the submit itself passes the mix through
    add_row(known_row(CMD_SUBMIT, 'h7fffff, 'h800000, 7, -7, 7, -7, 0, 0, 1));
    add_row(known_row(CMD_DRAIN, 0, 0, 0, 0, 32767, -32768, 1, 0, 0));
    // unity in, unity out; one lsb truncates to zero from either side
    add_row(op_row(CMD_SUBMIT, 'h400000, 'hc00000, 'h1234, -32768));
    add_row(op_row(CMD_SUBMIT, 1, -1, 0, 0));
    add_row(op_row(CMD_DRAIN, 0, 0, 32767, -32768));
    add_row(op_row(CMD_DRAIN, 0, 0, -32768, 32767));
    add_row(known_row(CMD_SHUTDOWN, 0, 0, 5, 6, 5, 6, 0, 0, 0));
    // one-pair frames, two-pair limit, top gain: drops and credit returns
    add_row(wr_row(REG_FRAME, 1));
    add_row(wr_row(REG_LIMIT, 2));
    add_row(wr_row(REG_GAIN, 'hffff));
    add_row(op_row(CMD_SUBMIT, 'h155555, 'heaaaab, 0, 0));
    add_row(op_row(CMD_SUBMIT, 'h7fffff, 'h800000, 0, 0));
    add_row(op_row(CMD_SUBMIT, 'h0003ff, 'hfffc01, 0, 0));
    add_row(op_row(CMD_DRAIN, 0, 0, 100, -100));
    add_row(known_row(CMD_SHUTDOWN, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    // paused with zero gain, frame size and limit of zero act as one
    add_row(wr_row(REG_PAUSED, 1));
    add_row(wr_row(REG_GAIN, 0));
    add_row(wr_row(REG_FRAME, 0));
    add_row(wr_row(REG_LIMIT, 0));
    add_row(op_row(CMD_SUBMIT, 'h7fffff, 'h800000, 0, 0));
    add_row(op_row(CMD_SUBMIT, 'h2abcde, 'hd54321, 0, 0));
    add_row(op_row(CMD_DRAIN, 0, 0, 1, -1));
    // frame shrinks mid-frame: the next submit closes it
    add_row(wr_row(REG_PAUSED, 0));
    add_row(wr_row(REG_GAIN, 16384));
    add_row(wr_row(REG_FRAME, 3));
    add_row(wr_row(REG_LIMIT, QUEUE_DEPTH));
    add_row(op_row(CMD_SUBMIT, 'h123456, 'hedcba9, 0, 0));
    add_row(op_row(CMD_SUBMIT, 'h000100, 'hffff00, 0, 0));
    add_row(wr_row(REG_FRAME, 2));
    add_row(op_row(CMD_SUBMIT, 'h3fffff, 'hc00001, 0, 0));
    add_row(op_row(CMD_DRAIN, 0, 0, 32767, -32768));
    // oversized frame and limit clamp to their maxima
    add_row(wr_row(REG_FRAME, 2047));
    add_row(wr_row(REG_LIMIT, 32767));
    add_row(wr_row(REG_GAIN, 8192));
    add_row(op_row(CMD_SUBMIT, 'h7fffff, 'h800000, 0, 0));
    add_row(op_row(CMD_SUBMIT, 'h5a5a5a, 'ha5a5a5, 0, 0));
    add_row(op_row(CMD_DRAIN, 0, 0, -1, 1));
    add_row(op_row(CMD_SHUTDOWN, 0, 0, 'h7fff, 'h8000));
    add_row(op_row(CMD_DRAIN, 0, 0, 'h0f0f, 'hf0f0));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        go_idle();
        write_reg(plan[i].sel, plan[i].wdata);
      end else begin
        send(plan[i]);
      end
    end

    // random phases, each with a fresh configuration; small limits and short
    // frames dominate so that drops and credit returns happen often
    for (int ph = 0; ph < 8; ph++) begin
      go_idle();
      case ($urandom_range(0, 4))
        0: v = 16'd16384;
        1: v = 16'd0;
        2: v = 16'hffff;
        default: v = CFG_DATA_W'($urandom());
      endcase
      write_reg(REG_GAIN, v);
      write_reg(REG_PAUSED, ($urandom_range(0, 4) == 0) ? 16'd1 : CFG_DATA_W'($urandom()) & 16'hfffe);
      case ($urandom_range(0, 7))
        0: v = 16'd0;
        1: v = 16'd768;
        2: v = 16'd1024;
        3: v = CFG_DATA_W'($urandom());
        default: v = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      write_reg(REG_FRAME, v);
      case ($urandom_range(0, 7))
        0: v = 16'd0;
        1: v = 16'd16000;
        2: v = CFG_DATA_W'(QUEUE_DEPTH);
        3: v = CFG_DATA_W'($urandom());
        default: v = CFG_DATA_W'($urandom_range(1, 40));
      endcase
      write_reg(REG_LIMIT, v);

      steady_send = (ph % 3 == 2);
      sub_pct     = $urandom_range(35, 70);
      for (int n = 0; n < 200; n++) begin
        it    = op_row(CMD_SUBMIT, 0, 0, 0, 0);
        roll  = $urandom_range(0, 99);
        if (roll < 3) it.cmd = CMD_SHUTDOWN;
        else if (roll < 6) it.cmd = CMD_UNUSED;
        else if (roll < 6 + sub_pct) it.cmd = CMD_SUBMIT;
        else it.cmd = CMD_DRAIN;
        it.ls = pick_sample();
        it.rs = pick_sample();
        it.ml = pick_mix();
        it.mr = pick_mix();
        send(it);
      end
    end
    steady_send = 1'b0;

    // drain every owed result, then a margin past the slowest item
    go_idle();
    repeat (30) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
